// ===== rtl/core/tlc_pkg.sv =====
// Shared types and default constants for the truncated linear convolution block.
package tlc_pkg;

	// Default configuration
	localparam int MAX_LEN_DEF      = 64;
	localparam int SAMPLE_WIDTH_DEF = 32;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} tlc_state_t;

	// Control from the sequencer to the multiply-accumulate unit
	typedef struct packed {
		logic clear;   // zero the accumulator
		logic mul_en;  // operands valid, capture product
		logic acc_en;  // product valid, add into accumulator
	} mac_ctrl_t;

endpackage

// ===== rtl/core/tlc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tlc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/tlc_mac.sv =====
// Shared multiply-accumulate unit with round-half-up and saturation of the sum.
module tlc_mac #(
	parameter int MAX_LEN      = tlc_pkg::MAX_LEN_DEF,
	parameter int SAMPLE_WIDTH = tlc_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  tlc_pkg::mac_ctrl_t             ctrl,
	input  logic signed [SAMPLE_WIDTH-1:0] op_a,
	input  logic signed [SAMPLE_WIDTH-1:0] op_b,
	output logic        [SAMPLE_WIDTH-1:0] value,
	output logic                           sat
);
	import tlc_pkg::*;

	localparam int W     = SAMPLE_WIDTH;
	localparam int FRAC  = W - 2;
	localparam int PW    = 2 * W;
	localparam int GUARD = $clog2(MAX_LEN + 1) + 1;
	localparam int ACC_W = PW + GUARD;
	localparam int HI_W  = ACC_W - W + 1;
	localparam logic [ACC_W-1:0] HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (FRAC - 1);

	logic signed [PW-1:0]    prod_s2;
	logic        [ACC_W-1:0] acc_q;
	logic        [ACC_W-1:0] rnd;
	logic signed [ACC_W-1:0] shifted;
	logic        [HI_W-1:0]  hi_bits;
	logic                    fits;
	logic                    neg;

	// Product register
	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s2 <= op_a * op_b;
		end
	end

	// Accumulator, exact: wide enough for MAX_LEN full-scale products
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_q <= acc_q + {{GUARD{prod_s2[PW-1]}}, prod_s2};
		end
	end

	// Round half up to FRAC fraction bits, then clamp to the sample range
	always_comb begin
		rnd     = acc_q + HALF;
		shifted = $signed(rnd) >>> FRAC;
		hi_bits = shifted[ACC_W-1:W-1];
		fits    = (&hi_bits) | ~(|hi_bits);
		neg     = shifted[ACC_W-1];
		sat     = ~fits;
		if (fits) begin
			value = shifted[W-1:0];
		end else if (neg) begin
			value = {1'b1, {(W-1){1'b0}}};
		end else begin
			value = {1'b0, {(W-1){1'b1}}};
		end
	end

endmodule

// ===== rtl/core/truncated_linear_convolution_top.sv =====
// Top level of the truncated causal linear convolution block.
// Each input word carries element j of sequences a and b (signed, SAMPLE_WIDTH bits,
// two integer bits) plus a first flag that restarts at element 0; reset also starts a
// sequence. The block stores both elements and returns one word per input: output j,
// the sum over k<=j of a[k]*b[j-k], rounded half up and saturated, with saturated set
// when clamped. Elements at index MAX_LEN or beyond are dropped and answered with value
// 0 and too_long set until the next first. A single multiplier, fed by the two sample
// RAMs one product per cycle, does all the work: for an item at index j the sequencer
// issues the j+1 reads in RUN, waits in DRAIN until the pipeline is empty and then
// writes the result into the output register in FINISH once that register is free;
// a dropped item goes from acceptance straight to FINISH. The input is not ready while
// an item is in progress. The result sits in an output register, so a stalled consumer
// only holds the block once a second result is finished.
module truncated_linear_convolution_top #(
	parameter int MAX_LEN      = tlc_pkg::MAX_LEN_DEF,
	parameter int SAMPLE_WIDTH = tlc_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_a,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_b,
	input  logic                           first,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] conv_value,
	output logic                           saturated,
	output logic                           too_long
);
	import tlc_pkg::*;

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int PW = $clog2(MAX_LEN + 1);
	localparam logic [PW-1:0] LEN = PW'(MAX_LEN);

	tlc_state_t state_q, state_d;

	logic [PW-1:0]           pos_q;
	logic [PW-1:0]           eff_pos;
	logic                    in_acc;
	logic                    drop;
	logic [AW-1:0]           j_q;
	logic [AW-1:0]           k_q;
	logic                    tl_q;
	logic                    rd_vld_s1;
	logic                    mul_vld_s2;
	logic                    last_issue;
	logic                    pipe_empty;
	logic                    out_free;
	logic                    ram_we;
	logic [AW-1:0]           raddr_b;
	logic [SAMPLE_WIDTH-1:0] rdata_a;
	logic [SAMPLE_WIDTH-1:0] rdata_b;
	logic [SAMPLE_WIDTH-1:0] mac_value;
	logic                    mac_sat;
	mac_ctrl_t               mac_ctrl;

	// Input word decode
	assign in_acc     = in_valid & in_ready;
	assign eff_pos    = first ? '0 : pos_q;
	assign drop       = (eff_pos >= LEN);
	assign last_issue = (k_q == j_q);
	assign pipe_empty = ~rd_vld_s1 & ~mul_vld_s2;
	assign out_free   = ~out_valid | out_ready;
	assign raddr_b    = j_q - k_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = drop ? ST_FINISH : ST_RUN;
				end
			end
			ST_RUN: begin
				if (last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (pipe_empty) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_ready        = (state_q == ST_IDLE);
		ram_we          = in_acc & ~drop;
		mac_ctrl.clear  = in_acc;
		mac_ctrl.mul_en = rd_vld_s1;
		mac_ctrl.acc_en = mul_vld_s2;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pos_q      <= '0;
			rd_vld_s1  <= 1'b0;
			mul_vld_s2 <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_vld_s1  <= (state_q == ST_RUN);
			mul_vld_s2 <= rd_vld_s1;
			if (in_acc) begin
				pos_q <= drop ? LEN : eff_pos + PW'(1);
			end
			if (state_q == ST_FINISH && out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Item bookkeeping: element index and product counter
	always_ff @(posedge clk) begin
		if (in_acc) begin
			j_q  <= eff_pos[AW-1:0];
			k_q  <= '0;
			tl_q <= drop;
		end else if (state_q == ST_RUN && !last_issue) begin
			k_q <= k_q + AW'(1);
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			conv_value <= tl_q ? '0 : mac_value;
			saturated  <= tl_q ? 1'b0 : mac_sat;
			too_long   <= tl_q;
		end
	end

	// Sample stores
	tlc_ram #(
		.WIDTH(SAMPLE_WIDTH),
		.DEPTH(MAX_LEN)
	) u_store_a (
		.clk  (clk),
		.we   (ram_we),
		.waddr(eff_pos[AW-1:0]),
		.wdata(sample_a),
		.raddr(k_q),
		.rdata(rdata_a)
	);

	tlc_ram #(
		.WIDTH(SAMPLE_WIDTH),
		.DEPTH(MAX_LEN)
	) u_store_b (
		.clk  (clk),
		.we   (ram_we),
		.waddr(eff_pos[AW-1:0]),
		.wdata(sample_b),
		.raddr(raddr_b),
		.rdata(rdata_b)
	);

	// Shared multiply-accumulate
	tlc_mac #(
		.MAX_LEN     (MAX_LEN),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_mac (
		.clk  (clk),
		.ctrl (mac_ctrl),
		.op_a ($signed(rdata_a)),
		.op_b ($signed(rdata_b)),
		.value(mac_value),
		.sat  (mac_sat)
	);

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the truncated linear convolution block.
module tb_top;

	localparam int SW             = tlc_pkg::SAMPLE_WIDTH_DEF;
	localparam int LEN            = tlc_pkg::MAX_LEN_DEF;
	localparam int FRAC           = SW - 2;
	localparam int ACC_W          = 2 * SW + 8;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = LEN + 16;
	localparam int MAX_REPORTS    = 10;

	localparam logic signed [SW-1:0] S_MAX  = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] S_MIN  = {1'b1, {(SW-1){1'b0}}};
	localparam logic signed [SW-1:0] S_ONE  = SW'(1) << FRAC;
	localparam logic signed [SW-1:0] S_HALF = SW'(1) << (FRAC - 1);

	// One result word as the block returns it
	typedef struct packed {
		logic signed [SW-1:0] value;
		logic                 sat;
		logic                 too_long;
	} conv_word_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic signed [SW-1:0] sample_a  = '0;
	logic signed [SW-1:0] sample_b  = '0;
	logic                 first     = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic signed [SW-1:0] conv_value;
	logic                 saturated;
	logic                 too_long;

	// Predictor state: both sequences so far and the next element index
	logic signed [SW-1:0] seq_a [LEN];
	logic signed [SW-1:0] seq_b [LEN];
	int                   seq_pos = 0;

	conv_word_t pending_conv_q [$];
	conv_word_t want_word;

	bit idle_en  = 1'b1;
	bit hold_req = 1'b0;
	int stall_left     = 0;
	int quiet_cycles   = 0;
	int words_sent     = 0;
	int seqs_started   = 0;
	int results_seen   = 0;
	int sat_seen       = 0;
	int dropped_seen   = 0;
	int mismatch_count = 0;

	truncated_linear_convolution_top #(
		.MAX_LEN      (LEN),
		.SAMPLE_WIDTH (SW)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_a   (sample_a),
		.sample_b   (sample_b),
		.first      (first),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.conv_value (conv_value),
		.saturated  (saturated),
		.too_long   (too_long)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Store element j (or drop it past the length limit), sum a[k]*b[j-k] exactly, round half up, then clamp
	function automatic conv_word_t compute_conv_word(input logic signed [SW-1:0] a,
			input logic signed [SW-1:0] b, input logic f);
		conv_word_t             w;
		logic signed [ACC_W-1:0] acc;
		logic signed [ACC_W-1:0] half;
		logic signed [ACC_W-1:0] rounded;
		logic signed [ACC_W-1:0] max_v;
		logic signed [ACC_W-1:0] min_v;
		logic signed [2*SW-1:0]  prod;
		int                      j;
		int                      k;
		w = '0;
		if (f) begin
			seq_pos = 0;
		end
		if (seq_pos >= LEN) begin
			// past the length limit: dropped, reported as too long
			seq_pos = LEN;
			w.too_long = 1'b1;
			return w;
		end
		j = seq_pos;
		seq_a[j] = a;
		seq_b[j] = b;
		seq_pos = j + 1;
		acc = '0;
		for (k = 0; k <= j; k++) begin
			prod = seq_a[k] * seq_b[j-k];
			acc += prod;
		end
		half = '0;
		half[FRAC-1] = 1'b1;
		rounded = (acc + half) >>> FRAC;
		max_v = '0;
		max_v[SW-2:0] = '1;
		min_v = ~max_v;
		if (rounded > max_v) begin
			w.value = max_v[SW-1:0];
			w.sat = 1'b1;
		end else if (rounded < min_v) begin
			w.value = min_v[SW-1:0];
			w.sat = 1'b1;
		end else begin
			w.value = rounded[SW-1:0];
		end
		return w;
	endfunction

	// Mix of full-range, small, extreme and moderate samples
	function automatic logic signed [SW-1:0] rand_sample();
		logic signed [SW-1:0] r;
		r = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return r;
			4, 5: return SW'($urandom_range(0, 2047)) - SW'(1024);
			6: begin
				case ($urandom_range(0, 4))
					0: return S_MAX;
					1: return S_MIN;
					2: return S_ONE;
					3: return -S_ONE;
					default: return '1;
				endcase
			end
			default: return r >>> 4;
		endcase
	endfunction

	// Offer one word, wait for it to be taken, then log its expected result
	task automatic send_word(input logic signed [SW-1:0] a, input logic signed [SW-1:0] b,
			input logic f);
		int gap;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample_a <= a;
		sample_b <= b;
		first    <= f;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_conv_q.push_back(compute_conv_word(a, b, f));
		words_sent++;
		if (f) begin
			seqs_started++;
		end
	endtask

	// Reset alone opens a sequence, no first flag needed
	task automatic test_start_without_first();
		send_word(S_ONE, S_ONE, 1'b0);
		send_word(S_ONE, -S_ONE, 1'b0);
		send_word(rand_sample(), rand_sample(), 1'b0);
	endtask

	// Largest and smallest samples, exact range edges and clamping both ways
	task automatic test_extremes();
		send_word(S_MIN, S_MIN, 1'b1);
		send_word(S_MAX, S_MAX, 1'b0);
		send_word('0, '0, 1'b0);
		send_word('1, '1, 1'b0);
		send_word(S_MIN, S_MAX, 1'b1);
		send_word(S_MAX, S_MIN, 1'b1);
		send_word(S_MAX, S_MAX, 1'b1);
		send_word(S_ONE, S_MAX, 1'b1);
		send_word(S_ONE, S_MIN, 1'b1);
		send_word(-S_ONE, S_MIN, 1'b1);
		send_word('0, S_MIN, 1'b1);
	endtask

	// Half-LSB ties round toward plus infinity
	task automatic test_rounding_ties();
		send_word(SW'(1), S_HALF, 1'b1);
		send_word(-SW'(1), S_HALF, 1'b1);
		send_word(SW'(3), S_HALF, 1'b1);
		send_word(-SW'(3), S_HALF, 1'b1);
		send_word(SW'(1), S_HALF - SW'(1), 1'b1);
	endtask

	// Fill to the full length, overrun it, then restart
	task automatic test_length_limit();
		int i;
		for (i = 0; i < LEN + 3; i++) begin
			send_word(rand_sample() >>> 6, rand_sample() >>> 6, i == 0);
		end
		send_word(rand_sample(), rand_sample(), 1'b1);
	endtask

	// Consumer holds off while the sender keeps offering, so the input backs up
	task automatic test_output_hold();
		int i;
		hold_req = 1'b1;
		for (i = 0; i < 8; i++) begin
			send_word(rand_sample(), rand_sample(), i == 0);
		end
	endtask

	// Mostly short well-formed sequences, some long, a few overrunning or without first
	task automatic test_random_sequences(input int count);
		int sent;
		int len;
		int pick;
		int i;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 85) begin
				len = $urandom_range(1, 16);
			end else if (pick < 95) begin
				len = $urandom_range(17, LEN);
			end else begin
				len = $urandom_range(LEN + 1, LEN + 6);
			end
			for (i = 0; i < len && sent < count; i++) begin
				send_word(rand_sample(), rand_sample(),
					(i == 0) && ($urandom_range(0, 19) != 0));
				sent++;
			end
		end
	endtask

	// Result side: random stall bursts, plus the one long hold on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (idle_en && $urandom_range(0, 9) == 0) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(0, 14);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Compare each returned word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_conv_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS) begin
					$display("ERROR: word with nothing expected: value=%0d sat=%b too_long=%b",
						conv_value, saturated, too_long);
				end
			end else begin
				want_word = pending_conv_q.pop_front();
				sat_seen += want_word.sat;
				dropped_seen += want_word.too_long;
				if (conv_value !== want_word.value || saturated !== want_word.sat ||
						too_long !== want_word.too_long) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display({"ERROR: result %0d expected value=%0d sat=%b too_long=%b,",
							" got value=%0d sat=%b too_long=%b"},
							results_seen, want_word.value, want_word.sat, want_word.too_long,
							conv_value, saturated, too_long);
					end
				end
			end
		end
	end

	// Watchdog: ends the run if no word moves on either side for too long
	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("ERROR: no word moved for %0d cycles", WATCHDOG_LIMIT);
		$display("truncated_linear_convolution_top: mismatch");
		$finish;
	end

	// Test sequence
	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		test_start_without_first();
		test_extremes();
		test_rounding_ties();
		test_length_limit();
		test_output_hold();
		test_random_sequences(555);
		idle_en = 1'b0;
		test_random_sequences(100);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_conv_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		mismatch_count += pending_conv_q.size();
		$display("Sent %0d words in %0d started sequences, %0d results checked.",
			words_sent, seqs_started, results_seen);
		$display("%0d results clamped, %0d dropped past the length limit, %0d mismatches.",
			sat_seen, dropped_seen, mismatch_count);
		if (mismatch_count == 0) begin
			$display("truncated_linear_convolution_top: match");
		end else begin
			$display("truncated_linear_convolution_top: mismatch");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/tlc_pkg.sv
rtl/core/tlc_ram.sv
rtl/core/tlc_mac.sv
rtl/core/truncated_linear_convolution_top.sv
sim/tb_top.sv
